FILE: hw/rtl/dpll_pkg.sv
// ----------------------------------------------------------------------------
// dpll_pkg
// Shared widths, constants and types for the dark pixel luminance lift.
// ----------------------------------------------------------------------------
`default_nettype none

package dpll_pkg;

    // Q1.16 unity and hue angles in sixteenths of a degree
    localparam logic [16:0] ONE_Q16   = 17'd65536;
    localparam logic [16:0] HALF_Q16  = 17'd32768;
    localparam logic [12:0] HUE_FULL  = 13'd5760;
    localparam logic [12:0] HUE_THIRD = 13'd1920;
    localparam logic [12:0] HUE_2THRD = 13'd3840;
    localparam logic [9:0]  HUE_SIXTH = 10'd960;

    // pipelined divider geometry (one quotient bit per stage)
    localparam int unsigned DIV_DW = 24;
    localparam int unsigned DIV_VW = 9;
    localparam int unsigned DIV_QW = 17;

    // lightness = sm * 32768 / 255 as (sm * LIGHT_RECIP) >> 16, exact for sm <= 510
    localparam logic [23:0] LIGHT_RECIP = 24'd8421505;
    localparam logic [8:0] SUM_FULL  = 9'd510;
    localparam logic [8:0] SUM_HALF  = 9'd255;

    // x / 15 as (x * RECIP_15) >> RECIP_SHIFT, exact for x < 2^22
    localparam logic [22:0] RECIP_15    = 23'd4473925;
    localparam int unsigned RECIP_SHIFT = 26;

    localparam logic [7:0] BYTE_MAX = 8'd255;

    // register reset values
    localparam logic [16:0] THR_RESET    = 17'd41943;
    localparam logic [16:0] GAIN_RESET   = 17'd6554;
    localparam logic [16:0] OFFSET_RESET = 17'd32768;

    typedef enum logic [1:0] {
        CFG_THRESHOLD = 2'd0,
        CFG_GAIN      = 2'd1,
        CFG_OFFSET    = 2'd2
    } cfg_idx_t;

    // travels beside the dividers
    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [12:0] hue_base;
        logic        hue_neg;
        logic        grey;
        logic [16:0] light;
    } side_t;

    // travels through the back-conversion stages
    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        dark;
        logic [12:0] hue;
        logic [16:0] sat;
        logic [16:0] light;
    } pix_t;

endpackage

`default_nettype wire

FILE: hw/rtl/dark_pixel_luminance_lift_core.sv
// ----------------------------------------------------------------------------
// dark_pixel_luminance_lift_core
// RGB -> HSL, lift of dark lightness, HSL -> RGB, one pixel per clock.
// ----------------------------------------------------------------------------
// Path: input register, divider stages, stages E to J, output register.
// Throughput: one pixel per clock; the whole pipeline advances together,
//   held only while the output register waits on m_tready.
// Depth is set by the 17-stage divider (one quotient bit per stage).
// Reset (aresetn low, synchronous): all valid bits clear, registers take
//   their documented reset values; the pipeline is empty.
`default_nettype none

module dark_pixel_luminance_lift_core (
    input  logic        aclk,
    input  logic        aresetn,
    // pixel requests
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // in_red, in_green, in_blue
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,    // out_red, out_green, out_blue, hue_value,
                                    // sat_value, light_value, zero pad
    output logic [0:0]  m_tuser,    // lifted
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    import dpll_pkg::*;

    localparam logic signed [14:0] PH_FULL  = 15'(HUE_FULL);
    localparam logic signed [14:0] PH_THIRD = 15'(HUE_THIRD);
    localparam logic signed [14:0] PH_SIXTH = 15'(HUE_SIXTH);
    localparam logic signed [14:0] PH_HALF  = 15'(HUE_THIRD) + 15'(HUE_SIXTH);
    localparam logic signed [14:0] PH_2THRD = 15'(HUE_2THRD);

    // Weight of (q - p) for one colour phase, in 1/960:
    // rising edge t, plateau 960 (gives q), falling edge, floor 0 (gives p).
    function automatic logic [9:0] phase_weight(input logic signed [14:0] t_in);
        logic signed [14:0] t;
        logic [9:0]         w;
        t = t_in;
        if (t < 0) begin
            t = t + PH_FULL;
        end else if (t > PH_FULL) begin
            t = t - PH_FULL;
        end
        if (t < PH_SIXTH) begin
            w = t[9:0];
        end else if (t < PH_HALF) begin
            w = HUE_SIXTH;
        end else if (t < PH_2THRD) begin
            w = 10'(PH_2THRD - t);
        end else begin
            w = '0;
        end
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Register port. Word addressed, index in paddr[3:2]; writes past
    // the last register are dropped.
    // ------------------------------------------------------------------
    logic [16:0] thr_reg;
    logic [16:0] gain_reg;
    logic [16:0] offset_reg;
    cfg_idx_t    cfg_idx;
    logic        cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = cfg_idx_t'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg    <= THR_RESET;
            gain_reg   <= GAIN_RESET;
            offset_reg <= OFFSET_RESET;
        end else if (cfg_wr) begin
            case (cfg_idx)
                CFG_THRESHOLD: thr_reg    <= pwdata[16:0];
                CFG_GAIN:      gain_reg   <= pwdata[16:0];
                CFG_OFFSET:    offset_reg <= pwdata[16:0];
                default:       ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            CFG_THRESHOLD: prdata = {15'd0, thr_reg};
            CFG_GAIN:      prdata = {15'd0, gain_reg};
            CFG_OFFSET:    prdata = {15'd0, offset_reg};
            default:       prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline advance. Every stage moves when the output register is
    // empty or being drained, so a stall freezes everything in place.
    // ------------------------------------------------------------------
    logic en;
    logic m_valid_reg;

    assign en       = !m_valid_reg || m_tready;
    assign s_tready = en;

    // ---- stage 1: input register -------------------------------------
    logic       in_valid_reg;
    logic [7:0] in_red_reg, in_green_reg, in_blue_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (en) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            in_red_reg   <= s_tdata[7:0];
            in_green_reg <= s_tdata[15:8];
            in_blue_reg  <= s_tdata[23:16];
        end
    end

    // ---- max / min, hue sector, divider operands ---------------------
    logic [7:0]  mx, mn, dif, hx;
    logic [8:0]  sm, sat_den;
    logic [12:0] hue_base;
    logic        hue_neg;
    logic [DIV_DW-1:0] hue_num, sat_num;
    logic [DIV_VW-1:0] hue_den;
    logic [32:0] light_prod;

    always_comb begin
        mx = in_red_reg;
        if (in_green_reg > mx) mx = in_green_reg;
        if (in_blue_reg > mx)  mx = in_blue_reg;
        mn = in_red_reg;
        if (in_green_reg < mn) mn = in_green_reg;
        if (in_blue_reg < mn)  mn = in_blue_reg;
        dif = mx - mn;
        sm  = {1'b0, mx} + {1'b0, mn};

        // ties go red, then green, then blue
        if (mx == in_red_reg) begin
            hue_neg  = in_green_reg < in_blue_reg;
            hue_base = hue_neg ? HUE_FULL : '0;
            hx       = hue_neg ? in_blue_reg - in_green_reg : in_green_reg - in_blue_reg;
        end else if (mx == in_green_reg) begin
            hue_neg  = in_blue_reg < in_red_reg;
            hue_base = HUE_THIRD;
            hx       = hue_neg ? in_red_reg - in_blue_reg : in_blue_reg - in_red_reg;
        end else begin
            hue_neg  = in_red_reg < in_green_reg;
            hue_base = HUE_2THRD;
            hx       = hue_neg ? in_green_reg - in_red_reg : in_red_reg - in_green_reg;
        end

        sat_den = (sm <= SUM_HALF) ? sm : SUM_FULL - sm;
        if (dif == '0) sat_den = 9'd1;
    end

    assign hue_num   = DIV_DW'(hx) * DIV_DW'(HUE_SIXTH);
    assign hue_den   = (dif == '0) ? DIV_VW'(1) : DIV_VW'(dif);
    assign sat_num   = {dif, 16'd0};

    // lightness by reciprocal multiplication, carried beside the dividers
    assign light_prod = 33'(sm) * 33'(LIGHT_RECIP);

    // ---- stages 2..18: two dividers side by side ---------------------
    logic [DIV_QW-1:0] hue_q, sat_q;

    dpll_div #(.DW(DIV_DW), .VW(DIV_VW), .QW(DIV_QW)) u_div_hue (
        .aclk (aclk), .en (en), .num (hue_num), .den (hue_den), .quo (hue_q)
    );

    dpll_div #(.DW(DIV_DW), .VW(DIV_VW), .QW(DIV_QW)) u_div_sat (
        .aclk (aclk), .en (en), .num (sat_num), .den (sat_den), .quo (sat_q)
    );

    side_t side_reg [DIV_QW];
    logic  side_valid_reg [DIV_QW];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < DIV_QW; k++) side_valid_reg[k] <= 1'b0;
        end else if (en) begin
            side_valid_reg[0] <= in_valid_reg;
            for (int k = 1; k < DIV_QW; k++) side_valid_reg[k] <= side_valid_reg[k-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            side_reg[0] <= '{red: in_red_reg, green: in_green_reg, blue: in_blue_reg,
                             hue_base: hue_base, hue_neg: hue_neg, grey: (dif == '0),
                             light: light_prod[32:16]};
            for (int k = 1; k < DIV_QW; k++) side_reg[k] <= side_reg[k-1];
        end
    end

    // ---- stage E: assemble HSL, dark test, gain product --------------
    side_t       sd;
    logic [16:0] light_q;
    pix_t        pix_e_next;
    logic        e_valid_reg;
    pix_t        pix_e_reg;
    logic [33:0] gl_e_reg;

    assign sd      = side_reg[DIV_QW-1];
    assign light_q = sd.light;

    always_comb begin
        pix_e_next.red   = sd.red;
        pix_e_next.green = sd.green;
        pix_e_next.blue  = sd.blue;
        pix_e_next.hue   = sd.hue_neg ? sd.hue_base - hue_q[12:0]
                                      : sd.hue_base + hue_q[12:0];
        if (sd.grey) begin
            pix_e_next.sat = '0;
        end else begin
            pix_e_next.sat = (sat_q > ONE_Q16) ? ONE_Q16 : sat_q;
        end
        pix_e_next.light = light_q;
        pix_e_next.dark  = light_q < thr_reg;
    end

    // ---- stage F: lifted lightness -----------------------------------
    logic [18:0] ln_sum;
    logic        f_valid_reg;
    pix_t        pix_f_reg;
    logic [16:0] ln_f_reg;

    assign ln_sum = 19'(gl_e_reg[33:16]) + 19'(offset_reg);

    // ---- stage G: L * S ----------------------------------------------
    logic [33:0] ls_prod;
    logic        g_valid_reg;
    pix_t        pix_g_reg;
    logic [16:0] ln_g_reg;
    logic [17:0] ls_g_reg;

    assign ls_prod = 34'(ln_f_reg) * 34'(pix_f_reg.sat);

    // ---- stage H: q, p and phase weights -----------------------------
    logic [17:0] q_h, p_h_next, diff_h;
    logic signed [14:0] hue_s;
    logic        h_valid_reg;
    pix_t        pix_h_reg;
    logic [16:0] p_h_reg;
    logic [17:0] diff_h_reg;
    logic [9:0]  w_h_reg [3];

    assign q_h = (ln_g_reg < HALF_Q16) ? 18'(ln_g_reg) + ls_g_reg
                                       : 18'(ln_g_reg) + 18'(pix_g_reg.sat) - ls_g_reg;
    assign p_h_next = {ln_g_reg, 1'b0} - q_h;
    assign diff_h   = q_h - p_h_next;
    assign hue_s    = 15'(pix_g_reg.hue);

    // ---- stage I: (q - p) * weight -----------------------------------
    logic        i_valid_reg;
    pix_t        pix_i_reg;
    logic [16:0] p_i_reg;
    logic [27:0] prod_i_reg [3];

    // ---- stage J: divide by 960 as >> 6 then reciprocal of 15 --------
    logic [44:0] recip_j [3];
    logic        j_valid_reg;
    pix_t        pix_j_reg;
    logic [16:0] p_j_reg;
    logic [17:0] quot_j_reg [3];

    for (genvar c = 0; c < 3; c++) begin : g_recip
        assign recip_j[c] = 45'(prod_i_reg[c][27:6]) * 45'(RECIP_15);
    end

    // ---- stage K: p + share, clamp, back to bytes, output register ----
    logic [7:0]  byte_k [3];
    logic [7:0]  m_red_reg, m_green_reg, m_blue_reg;
    logic        m_lift_reg;
    logic [12:0] m_hue_reg;
    logic [16:0] m_sat_reg, m_light_reg;

    for (genvar c = 0; c < 3; c++) begin : g_byte
        logic [18:0] v;
        logic [16:0] vc;
        logic [24:0] scaled;
        assign v      = 19'(p_j_reg) + 19'(quot_j_reg[c]);
        assign vc     = (v > 19'(ONE_Q16)) ? ONE_Q16 : v[16:0];
        assign scaled = 25'(vc) * 25'(BYTE_MAX);
        assign byte_k[c] = scaled[23:16];
    end

    // valid line through the back-conversion stages
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
            g_valid_reg <= 1'b0;
            h_valid_reg <= 1'b0;
            i_valid_reg <= 1'b0;
            j_valid_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else if (en) begin
            e_valid_reg <= side_valid_reg[DIV_QW-1];
            f_valid_reg <= e_valid_reg;
            g_valid_reg <= f_valid_reg;
            h_valid_reg <= g_valid_reg;
            i_valid_reg <= h_valid_reg;
            j_valid_reg <= i_valid_reg;
            m_valid_reg <= j_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // E
            pix_e_reg <= pix_e_next;
            gl_e_reg  <= 34'(gain_reg) * 34'(light_q);
            // F
            pix_f_reg <= pix_e_reg;
            ln_f_reg  <= (ln_sum > 19'(ONE_Q16)) ? ONE_Q16 : ln_sum[16:0];
            // G
            pix_g_reg <= pix_f_reg;
            ln_g_reg  <= ln_f_reg;
            ls_g_reg  <= ls_prod[33:16];
            // H: red, green, blue phases are H + 120, H, H - 120 degrees
            pix_h_reg  <= pix_g_reg;
            p_h_reg    <= p_h_next[16:0];
            diff_h_reg <= diff_h;
            w_h_reg[0] <= phase_weight(hue_s + PH_THIRD);
            w_h_reg[1] <= phase_weight(hue_s);
            w_h_reg[2] <= phase_weight(hue_s - PH_THIRD);
            // I
            pix_i_reg <= pix_h_reg;
            p_i_reg   <= p_h_reg;
            for (int c = 0; c < 3; c++) begin
                prod_i_reg[c] <= 28'(diff_h_reg) * 28'(w_h_reg[c]);
            end
            // J
            pix_j_reg <= pix_i_reg;
            p_j_reg   <= p_i_reg;
            for (int c = 0; c < 3; c++) begin
                quot_j_reg[c] <= recip_j[c][RECIP_SHIFT+17:RECIP_SHIFT];
            end
            // K: a pixel that is not dark goes out as it came in
            m_red_reg   <= pix_j_reg.dark ? byte_k[0] : pix_j_reg.red;
            m_green_reg <= pix_j_reg.dark ? byte_k[1] : pix_j_reg.green;
            m_blue_reg  <= pix_j_reg.dark ? byte_k[2] : pix_j_reg.blue;
            m_lift_reg  <= pix_j_reg.dark;
            m_hue_reg   <= pix_j_reg.hue;
            m_sat_reg   <= pix_j_reg.sat;
            m_light_reg <= pix_j_reg.light;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, m_light_reg, m_sat_reg, m_hue_reg,
                       m_blue_reg, m_green_reg, m_red_reg};
    assign m_tuser  = m_lift_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    a_reset_empty : assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid straight after reset");

    a_lift_below_thr : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_lift_reg) |-> (m_light_reg < thr_reg))
        else $error("lifted pixel not below threshold");

    a_hsl_range : assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((m_hue_reg <= HUE_FULL) && (m_sat_reg <= ONE_Q16)
                      && (m_light_reg <= ONE_Q16)))
        else $error("HSL value out of range");

    a_grey_lift : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_lift_reg && (m_sat_reg == '0)) |->
            ((m_red_reg == m_green_reg) && (m_green_reg == m_blue_reg)))
        else $error("lifted grey pixel not grey");

endmodule

`default_nettype wire

FILE: hw/rtl/dpll_div.sv
// ----------------------------------------------------------------------------
// dpll_div
// Pipelined restoring divider, one quotient bit per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module dpll_div #(
    parameter int unsigned DW = dpll_pkg::DIV_DW,
    parameter int unsigned VW = dpll_pkg::DIV_VW,
    parameter int unsigned QW = dpll_pkg::DIV_QW
) (
    input  logic          aclk,
    input  logic          en,
    input  logic [DW-1:0] num,   // quotient must fit in QW bits
    input  logic [VW-1:0] den,   // non-zero
    output logic [QW-1:0] quo
);

    logic [VW-1:0] rem_reg [QW];
    logic [VW-1:0] den_reg [QW];
    logic [QW-1:0] low_reg [QW];
    logic [QW-1:0] quo_reg [QW];

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [VW-1:0] rem_in;
        logic [VW-1:0] den_in;
        logic [QW-1:0] low_in;
        logic [QW-1:0] quo_in;
        logic [VW:0]   trial;
        logic          take;

        if (k == 0) begin : g_first
            assign rem_in = VW'(num >> QW);
            assign den_in = den;
            assign low_in = num[QW-1:0];
            assign quo_in = '0;
        end else begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign low_in = low_reg[k-1];
            assign quo_in = quo_reg[k-1];
        end

        assign trial = {rem_in, low_in[QW-1]};
        assign take  = (trial >= {1'b0, den_in});

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= take ? VW'(trial - {1'b0, den_in}) : trial[VW-1:0];
                den_reg[k] <= den_in;
                low_reg[k] <= {low_in[QW-2:0], 1'b0};
                quo_reg[k] <= {quo_in[QW-2:0], take};
            end
        end
    end

    assign quo = quo_reg[QW-1];

endmodule

`default_nettype wire

FILE: tb/dark_pixel_luminance_lift_core_tb.sv
// ----------------------------------------------------------------------------
// dark_pixel_luminance_lift_core_tb
// Self-checking bench: streams RGB requests through the lift core, predicts
// each result from its own HSL model and compares every field in order.
// ----------------------------------------------------------------------------
`default_nettype none

module dark_pixel_luminance_lift_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import dpll_pkg::*;

    localparam int unsigned LATENCY   = 24;
    localparam int unsigned WATCHDOG  = 20000;
    localparam int unsigned N_RANDOM  = 1500;

    typedef struct packed {
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic        lifted;
        logic [12:0] hue;
        logic [16:0] sat;
        logic [16:0] light;
    } lift_result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    dark_pixel_luminance_lift_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // predictor's copy of the register file
    logic [16:0] thr_q;
    logic [16:0] gain_q;
    logic [16:0] offset_q;

    logic [23:0]  pixel_queue[$];   // requests waiting for the driver
    lift_result_t lift_expected[$]; // predicted results, oldest first

    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned lifted_seen;
    int unsigned idle_cycles;
    int unsigned burst_left;        // cycles of no idling left on both sides
    bit          hold_sender;       // pressure hold-off
    bit          timed_out;
    bit          in_taken;          // request accepted at the last rising edge

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    // Hue phase for one component of the back conversion.
    function automatic longint hue_phase(longint t, longint p, longint q);
        if (t < 0) t += HUE_FULL;
        if (t > HUE_FULL) t -= HUE_FULL;
        if (t < HUE_SIXTH) return p + ((q - p) * t) / HUE_SIXTH;
        if (t < 3 * HUE_SIXTH) return q;
        if (t < 4 * HUE_SIXTH) return p + ((q - p) * (4 * HUE_SIXTH - t)) / HUE_SIXTH;
        return p;
    endfunction

    function automatic logic [7:0] q16_to_byte(longint v);
        if (v < 0) v = 0;
        if (v > ONE_Q16) v = ONE_Q16;
        return 8'((v * 255) >>> 16);
    endfunction

    function automatic lift_result_t predict_lift(logic [23:0] px);
        lift_result_t res;
        longint r, g, b, mx, mn, d, sm, light, sat, hue, ln, q, p;
        r = px[7:0];
        g = px[15:8];
        b = px[23:16];
        mx = r; mn = r;
        if (g > mx) mx = g;
        if (b > mx) mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        d = mx - mn;
        sm = mx + mn;
        light = (sm * 65536) / 510;
        sat = 0;
        hue = 0;
        if (d != 0) begin
            // ties resolve red, then green, then blue
            if (mx == r) begin
                if (g >= b) hue = (960 * (g - b)) / d;
                else hue = 5760 - (960 * (b - g)) / d;
            end else if (mx == g) begin
                if (b >= r) hue = 1920 + (960 * (b - r)) / d;
                else hue = 1920 - (960 * (r - b)) / d;
            end else begin
                if (r >= g) hue = 3840 + (960 * (r - g)) / d;
                else hue = 3840 - (960 * (g - r)) / d;
            end
            if (sm <= 255) sat = (d * 65536) / sm;
            else sat = (d * 65536) / (510 - sm);
            if (sat > 65536) sat = 65536;
        end
        if (hue > 5760) hue = 5760;
        res.hue   = 13'(hue);
        res.sat   = 17'(sat);
        res.light = 17'(light);
        if (light < thr_q) begin
            ln = ((longint'(gain_q) * light) >>> 16) + offset_q;
            if (ln > 65536) ln = 65536;
            if (sat == 0) begin
                res.red   = q16_to_byte(ln);
                res.green = res.red;
                res.blue  = res.red;
            end else begin
                if (ln < 32768) q = (ln * (65536 + sat)) >>> 16;
                else q = ln + sat - ((ln * sat) >>> 16);
                p = 2 * ln - q;
                res.red   = q16_to_byte(hue_phase(hue + 1920, p, q));
                res.green = q16_to_byte(hue_phase(hue, p, q));
                res.blue  = q16_to_byte(hue_phase(hue - 1920, p, q));
            end
            res.lifted = 1'b1;
        end else begin
            res.red    = px[7:0];
            res.green  = px[15:8];
            res.blue   = px[23:16];
            res.lifted = 1'b0;
        end
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Driver: presents queued pixels, changes only on the falling edge
    // ------------------------------------------------------------------
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            m_tready <= 1'b0;
        end else begin
            if (burst_left != 0) burst_left <= burst_left - 1;
            m_tready <= (burst_left != 0) || ($urandom_range(99) >= 34);
            // a request presented and not yet taken stays put
            if (!s_tvalid || in_taken) begin
                if (pixel_queue.size() != 0 && !hold_sender
                    && ((burst_left != 0) || ($urandom_range(99) >= 34))) begin
                    s_tdata  <= pixel_queue.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predicts on accepted requests, checks accepted results
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        lift_result_t got;
        lift_result_t want;
        if (aresetn) begin
            in_taken <= s_tvalid && s_tready;
            if (s_tvalid && s_tready)
                lift_expected.push_back(predict_lift(s_tdata));
            if (m_tvalid && m_tready) begin
                got.red    = m_tdata[7:0];
                got.green  = m_tdata[15:8];
                got.blue   = m_tdata[23:16];
                got.hue    = m_tdata[36:24];
                got.sat    = m_tdata[53:37];
                got.light  = m_tdata[70:54];
                got.lifted = m_tuser[0];
                results_seen <= results_seen + 1;
                if (got.lifted) lifted_seen <= lifted_seen + 1;
                if (lift_expected.size() == 0) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display("error: unexpected result %h lifted=%0d", m_tdata, got.lifted);
                end else begin
                    want = lift_expected.pop_front();
                    if (got !== want) begin
                        mismatches = mismatches + 1;
                        if (mismatches <= 10)
                            $display({"error: rgb %0d,%0d,%0d lift %0d h %0d s %0d l %0d",
                                      " expected rgb %0d,%0d,%0d lift %0d h %0d s %0d l %0d"},
                                     got.red, got.green, got.blue, got.lifted, got.hue,
                                     got.sat, got.light, want.red, want.green, want.blue,
                                     want.lifted, want.hue, want.sat, want.light);
                    end
                end
            end
            // watchdog on cycles with no handshake at all
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Register writes: setup then access, only while the pipeline is empty
    // ------------------------------------------------------------------
    task automatic write_reg(cfg_idx_t idx, logic [16:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 4'(idx) << 2;
        pwdata  <= 32'(value);
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            CFG_THRESHOLD: thr_q    = value;
            CFG_GAIN:      gain_q   = value;
            CFG_OFFSET:    offset_q = value;
            default: ;
        endcase
    endtask

    // wait until every queued pixel is sent and every result has come back
    task automatic drain;
        while ((pixel_queue.size() != 0 || s_tvalid || lift_expected.size() != 0)
               && !timed_out)
            @(posedge aclk);
        repeat (LATENCY + 4) @(posedge aclk);
    endtask

    function automatic logic [23:0] pack_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        return {b, g, r};
    endfunction

    task automatic queue_random(int unsigned count);
        logic [7:0] base;
        for (int unsigned i = 0; i < count; i++) begin
            case ($urandom_range(3))
                0: begin
                    // dark region, where the lift does its work
                    pixel_queue.push_back(pack_pixel(8'($urandom_range(120)),
                        8'($urandom_range(120)), 8'($urandom_range(120))));
                end
                1: begin
                    // near-grey and tied components
                    base = 8'($urandom);
                    pixel_queue.push_back(pack_pixel(base, base + 8'($urandom_range(2)),
                        ($urandom_range(1) != 0) ? base : 8'($urandom)));
                end
                default: pixel_queue.push_back(24'($urandom));
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin
        logic [16:0] settings [5][3];
        settings = '{
            '{17'd41943, 17'd6554, 17'd32768},
            '{17'd65536, 17'd65536, 17'd65536},   // everything dark, saturated lift
            '{17'd0, 17'd0, 17'd0},               // nothing dark
            '{17'd65536, 17'd0, 17'd0},           // dark pixels go black
            '{17'd50000, 17'd40000, 17'd10000}
        };
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        thr_q = THR_RESET;
        gain_q = GAIN_RESET;
        offset_q = OFFSET_RESET;
        mismatches = 0;
        results_seen = 0;
        lifted_seen = 0;
        idle_cycles = 0;
        burst_left = 0;
        hold_sender = 1'b0;
        timed_out = 1'b0;
        in_taken = 1'b0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: extremes, greys, each maximum and tie, under reset registers
        pixel_queue.push_back(pack_pixel(8'd0, 8'd0, 8'd0));
        pixel_queue.push_back(pack_pixel(8'd255, 8'd255, 8'd255));
        pixel_queue.push_back(pack_pixel(8'd80, 8'd80, 8'd80));
        pixel_queue.push_back(pack_pixel(8'd255, 8'd0, 8'd0));
        pixel_queue.push_back(pack_pixel(8'd0, 8'd255, 8'd0));
        pixel_queue.push_back(pack_pixel(8'd0, 8'd0, 8'd255));
        pixel_queue.push_back(pack_pixel(8'd120, 8'd40, 8'd90));
        pixel_queue.push_back(pack_pixel(8'd30, 8'd100, 8'd10));
        pixel_queue.push_back(pack_pixel(8'd10, 8'd30, 8'd100));
        pixel_queue.push_back(pack_pixel(8'd100, 8'd100, 8'd20));
        pixel_queue.push_back(pack_pixel(8'd50, 8'd90, 8'd90));
        pixel_queue.push_back(pack_pixel(8'd255, 8'd254, 8'd0));
        pixel_queue.push_back(pack_pixel(8'd1, 8'd0, 8'd0));
        pixel_queue.push_back(pack_pixel(8'd128, 8'd127, 8'd255));
        pixel_queue.push_back(pack_pixel(8'd170, 8'd85, 8'd85));
        pixel_queue.push_back(pack_pixel(8'd200, 8'd255, 8'd200));
        drain();

        // pressure: sender held until the pipeline has emptied
        queue_random(40);
        wait (pixel_queue.size() < 20);
        hold_sender = 1'b1;
        while (lift_expected.size() != 0 && !timed_out) @(posedge aclk);
        hold_sender = 1'b0;
        drain();

        // a long stretch with no idling on either side
        burst_left = 300;
        queue_random(200);
        drain();

        for (int s = 1; s < 5; s++) begin
            write_reg(CFG_THRESHOLD, settings[s][0]);
            write_reg(CFG_GAIN, settings[s][1]);
            write_reg(CFG_OFFSET, settings[s][2]);
            queue_random(N_RANDOM / 6);
            drain();
        end

        // random register values, including the above-one range
        write_reg(CFG_THRESHOLD, 17'($urandom_range(65536)));
        write_reg(CFG_GAIN, 17'($urandom));
        write_reg(CFG_OFFSET, 17'($urandom));
        queue_random(N_RANDOM / 6);
        drain();

        $display("run covered %0d pixels checked, %0d of them lifted, over six register settings",
                 results_seen, lifted_seen);
        if (mismatches == 0 && !timed_out && lift_expected.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches, %0d results outstanding", mismatches, lift_expected.size());
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // watchdog: ends a stuck run
    initial begin
        wait (idle_cycles >= WATCHDOG);
        timed_out = 1'b1;
        $display("watchdog expired with %0d results outstanding", lift_expected.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
hw/rtl/dpll_pkg.sv
hw/rtl/dpll_div.sv
hw/rtl/dark_pixel_luminance_lift_core.sv
tb/dark_pixel_luminance_lift_core_tb.sv
